>>> sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg - shared types and constants for the positional byte list
// Capacity, derived widths, command and status codes, controller commands.
// ----------------------------------------------------------------------------
package pli_pkg;

	// list capacity and derived widths
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 6;
	localparam int LEN_W    = 6;
	localparam int VAL_W    = 8;
	localparam int CMD_W    = 2;
	localparam int ST_W     = 2;
	// compare width that holds both a position and a count plus one
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_POS  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the accepted input beat
		logic execute;  // run the latched command and load the result
	} ctl_cmd_t;

endpackage

>>> sv/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete - ordered list of bytes with positional edits
// Top level: sequencer plus storage datapath.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid/in_ready with cmd, position, value. One beat is
//                    one command: append, insert at, delete at or read at a
//                    1-based position.
//   output channel : out_valid/out_ready with read_value, list_length,
//                    is_empty and status. Exactly one result beat per command.
//   order          : the input beat is latched first; the command then runs
//                    once the output side is free, shifting the cell row and
//                    loading the result register, from which out_valid rises.
//   throughput     : one command at a time; a new beat is taken only after
//                    the previous command has run.
//   stalls         : a held result does not block the next input beat; that
//                    command waits in the latch until the result is taken.
//   reset          : arst_n empties the list (length zero); cell contents
//                    are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pli_pkg::CMD_W-1:0]    cmd,
	input  logic [pli_pkg::POS_W-1:0]    position,
	input  logic [pli_pkg::VAL_W-1:0]    value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pli_pkg::VAL_W-1:0]    read_value,
	output logic [pli_pkg::LEN_W-1:0]    list_length,
	output logic                         is_empty,
	output logic [pli_pkg::ST_W-1:0]     status
);
	import pli_pkg::*;

	ctl_cmd_t ctl;

	// sequencer
	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// storage and result datapath
	pli_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.read_value  (read_value),
		.list_length (list_length),
		.is_empty    (is_empty),
		.status      (status)
	);

`ifndef SYNTH
	// one command in flight: no second beat right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a command is in flight");

	// length never exceeds capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (list_length <= LEN_W'(CAPACITY)))
		else $error("list length above capacity");

	// a full refusal only happens on a full list
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (list_length == LEN_W'(CAPACITY)))
		else $error("full status with list not full");

	// a refused command returns a zero byte
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (read_value == '0))
		else $error("nonzero read byte on refused command");
`endif

endmodule

>>> sv/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl - command sequencer
// Accepts one input beat, runs it in the datapath once the result register
// is free, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module pli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pli_pkg::ctl_cmd_t ctl
);
	import pli_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	// result register can take a new beat
	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign ctl.capture = in_valid && in_ready;
	assign ctl.execute = (state_q == S_EXEC) && out_free;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.capture) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (ctl.execute) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (ctl.execute) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/pli_dpath.sv
// ----------------------------------------------------------------------------
// pli_dpath - list storage and result datapath
// Row of byte cells that shift up or down together when a command executes,
// the entry count, position checks and the result register.
// ----------------------------------------------------------------------------
module pli_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pli_pkg::ctl_cmd_t            ctl,
	input  logic [pli_pkg::CMD_W-1:0]    cmd,
	input  logic [pli_pkg::POS_W-1:0]    position,
	input  logic [pli_pkg::VAL_W-1:0]    value,
	output logic [pli_pkg::VAL_W-1:0]    read_value,
	output logic [pli_pkg::LEN_W-1:0]    list_length,
	output logic                         is_empty,
	output logic [pli_pkg::ST_W-1:0]     status
);
	import pli_pkg::*;

	logic [CMD_W-1:0] cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] entries_q [CAPACITY];

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] slot_x;
	logic [IDX_W-1:0] slot;
	logic             full;
	logic             ins_bad;
	logic             idx_bad;
	logic             do_app;
	logic             do_ins;
	logic             do_del;
	logic             do_rd;
	logic [CNT_W-1:0] count_d;
	logic [ST_W-1:0]  st_d;
	logic [VAL_W-1:0] rd_d;
	logic [CAPACITY-1:0] wr_en;
	logic [VAL_W-1:0] wr_data [CAPACITY];

	// latch the accepted beat
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= cmd;
			pos_q <= position;
			val_q <= value;
		end
	end

	// position and capacity checks
	assign pos_x   = CMP_W'(pos_q);
	assign cnt_x   = CMP_W'(count_q);
	assign slot_x  = pos_x - CMP_W'(1);
	assign slot    = slot_x[IDX_W-1:0];
	assign full    = (cnt_x >= CMP_W'(CAPACITY));
	assign ins_bad = (pos_q == '0) || (pos_x > cnt_x + CMP_W'(1));
	assign idx_bad = (pos_q == '0) || (pos_x > cnt_x);

	// command decode, new count and status
	always_comb begin
		do_app  = 1'b0;
		do_ins  = 1'b0;
		do_del  = 1'b0;
		do_rd   = 1'b0;
		st_d    = ST_OK;
		count_d = count_q;
		unique case (cmd_q)
			CMD_APPEND: begin
				if (full) st_d = ST_FULL;
				else begin
					do_app  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				if (full) st_d = ST_FULL;
				else if (ins_bad) st_d = ST_POS;
				else begin
					do_ins  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (idx_bad) st_d = ST_POS;
				else begin
					do_del  = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (idx_bad) st_d = ST_POS;
				else do_rd = 1'b1;
			end
			default: st_d = ST_OK;
		endcase
	end

	// read port
	assign rd_d = do_rd ? entries_q[slot] : '0;

	// per-cell next value: write, take lower neighbor, or take upper neighbor
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			wr_en[i]   = 1'b0;
			wr_data[i] = val_q;
			if (do_app && (CMP_W'(i) == cnt_x)) begin
				wr_en[i] = 1'b1;
			end else if (do_ins && (CMP_W'(i) == slot_x)) begin
				wr_en[i] = 1'b1;
			end else if (do_ins && (CMP_W'(i) > slot_x) && (CMP_W'(i) <= cnt_x)
					&& (i > 0)) begin
				wr_en[i]   = 1'b1;
				wr_data[i] = entries_q[(i > 0) ? i - 1 : 0];
			end else if (do_del && (CMP_W'(i) >= slot_x) && (CMP_W'(i + 1) < cnt_x)
					&& (i < CAPACITY - 1)) begin
				wr_en[i]   = 1'b1;
				wr_data[i] = entries_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	// cell row
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (ctl.execute && wr_en[i]) entries_q[i] <= wr_data[i];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.execute) begin
			count_q <= count_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			read_value  <= rd_d;
			list_length <= LEN_W'(count_d);
			is_empty    <= (count_d == '0);
			status      <= st_d;
		end
	end

endmodule
